// ----- hw/rtl/vmbm_pkg.sv -----
// ----------------------------------------------------------------------------
// vmbm_pkg
// Shared types and constants for the video mode best-match unit.
// ----------------------------------------------------------------------------
package vmbm_pkg;

    // Request codes
    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_FIND  = 2'd1,
        REQ_READ  = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    // Sequencer states, one-hot
    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_FETCH = 7'b0000010,
        ST_EVAL  = 7'b0000100,
        ST_DIFF  = 7'b0001000,
        ST_MUL   = 7'b0010000,
        ST_DIV   = 7'b0100000,
        ST_RDOUT = 7'b1000000
    } t_state;

    // One table entry as stored in memory
    typedef struct packed {
        logic [15:0] width;
        logic [15:0] height;
        logic [7:0]  depth;
    } t_entry;

    localparam int ENTRY_W = 40;

    // Score arithmetic
    localparam int AREA_W = 32;
    localparam int SCORE_W = 10;
    localparam int NUM_W = AREA_W + SCORE_W;
    localparam logic [SCORE_W-1:0] SCORE_LIMIT = 10'd1000;

    // Depth codes
    localparam logic [7:0] DEPTH_8  = 8'd8;
    localparam logic [7:0] DEPTH_16 = 8'd16;
    localparam logic [7:0] DEPTH_24 = 8'd24;
    localparam logic [7:0] DEPTH_32 = 8'd32;

    // Register indexes
    localparam logic REG_MODE_COUNT = 1'b0;

    function automatic logic is_deep(input logic [7:0] d);
        return (d == DEPTH_24) || (d == DEPTH_32);
    endfunction

endpackage

// ----- hw/rtl/video_mode_best_match_unit.sv -----
// ----------------------------------------------------------------------------
// video_mode_best_match_unit
// Display mode table with a best-match search over its valid entries.
// ----------------------------------------------------------------------------
// Usage: pulse start with a request while busy is low. Exactly one result word
// follows on o_done, and it cannot be stalled. A write completes straight from
// idle, and a read passes through the fetch and read-out states. A find scans
// the entries in order: an exact hit ends the scan, an entry that is ruled out
// is skipped, and a scored entry waits for the score divider. The table
// memory is not cleared, so entries must be written before a find or a read
// reaches them. mode_count is written over the APB-style port at address 0.
// ----------------------------------------------------------------------------
module video_mode_best_match_unit #(
    parameter int MAX_MODES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // request
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_req_type,
    input  logic [5:0]  i_entry_index,
    input  logic [15:0] i_req_width,
    input  logic [15:0] i_req_height,
    input  logic [7:0]  i_req_depth,
    // result
    output logic        o_done,
    output logic        o_status,
    output logic [5:0]  o_mode_index,
    output logic [15:0] o_mode_width,
    output logic [15:0] o_mode_height,
    output logic [7:0]  o_mode_depth
);

    localparam int IW = $clog2(MAX_MODES);
    localparam int CW = $clog2(MAX_MODES + 1);
    localparam int NW = (CW > 7) ? CW : 7;
    localparam int AW = vmbm_pkg::AREA_W;
    localparam int QW = vmbm_pkg::SCORE_W;
    localparam logic [IW+5:0] MAX_IDX = (IW + 6)'(MAX_MODES);
    localparam logic [NW-1:0] MAX_CNT = NW'(MAX_MODES);

    vmbm_pkg::t_state r_state, n_state;

    logic [6:0]             r_mode_count;
    logic [IW-1:0]          r_idx, n_idx;
    vmbm_pkg::t_entry       r_req, n_req;
    logic [AW-1:0]          r_area, n_area;
    vmbm_pkg::t_entry       r_ent, n_ent;
    logic [AW-1:0]          r_ea, n_ea;
    logic                   r_elig, n_elig;
    logic                   r_half, n_half;
    logic [AW-1:0]          r_diff, n_diff;
    logic [QW-1:0]          r_best_score, n_best_score;
    logic [IW-1:0]          r_best_idx, n_best_idx;
    vmbm_pkg::t_entry       r_best, n_best;
    logic                   r_found, n_found;

    logic                   r_done, n_done;
    logic                   r_status, n_status;
    logic [5:0]             r_oidx, n_oidx;
    vmbm_pkg::t_entry       r_out, n_out;

    logic                   cfg_wr;
    logic                   accept;
    logic [IW+5:0]          idx_ext;
    logic                   wr_ok;
    logic [NW-1:0]          eff_cnt;
    logic                   rd_ok;
    logic                   ram_we;
    logic [vmbm_pkg::ENTRY_W-1:0] ram_rdata;
    vmbm_pkg::t_entry       rd_ent;
    vmbm_pkg::t_entry       in_ent;
    logic                   last;
    logic                   div_start;
    logic [vmbm_pkg::NUM_W-1:0] div_num;
    logic                   div_done;
    logic [QW-1:0]          div_quo;
    logic [QW-1:0]          score;
    logic [IW+5:0]          idx_wide;
    logic [IW+5:0]          best_wide;
    logic                   d_narrow;
    logic                   d_deep;

    // configuration register
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == vmbm_pkg::REG_MODE_COUNT) ? {25'd0, r_mode_count} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode_count <= '0;
        end else if (cfg_wr && paddr[2] == vmbm_pkg::REG_MODE_COUNT) begin
            r_mode_count <= pwdata[6:0];
        end
    end

    // request decode
    assign busy    = (r_state != vmbm_pkg::ST_IDLE);
    assign accept  = start && !busy;
    assign idx_ext = {{IW{1'b0}}, i_entry_index};
    assign wr_ok   = idx_ext < MAX_IDX;
    assign eff_cnt = (NW'(r_mode_count) >= MAX_CNT) ? MAX_CNT : NW'(r_mode_count);
    assign rd_ok   = NW'(i_entry_index) < eff_cnt;
    assign in_ent  = '{width: i_req_width, height: i_req_height, depth: i_req_depth};
    assign ram_we  = accept && (i_req_type == vmbm_pkg::REQ_WRITE) && wr_ok;

    vmbm_ram #(
        .WIDTH (vmbm_pkg::ENTRY_W),
        .DEPTH (MAX_MODES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (idx_ext[IW-1:0]),
        .i_wdata (in_ent),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    assign rd_ent = vmbm_pkg::t_entry'(ram_rdata);

    // score divider; an equal deep depth scales by half the limit, halving the score
    assign div_start = (r_state == vmbm_pkg::ST_MUL);
    assign div_num   = r_half
        ? vmbm_pkg::NUM_W'(r_diff) * vmbm_pkg::NUM_W'(vmbm_pkg::SCORE_LIMIT >> 1)
        : vmbm_pkg::NUM_W'(r_diff) * vmbm_pkg::NUM_W'(vmbm_pkg::SCORE_LIMIT);

    vmbm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_area),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign last      = (NW'(r_idx) + 1'b1) >= eff_cnt;
    assign score     = div_quo;
    assign idx_wide  = {6'd0, r_idx};
    assign best_wide = {6'd0, r_best_idx};
    assign d_narrow  = (r_req.depth == vmbm_pkg::DEPTH_8) || (r_req.depth == vmbm_pkg::DEPTH_16);
    assign d_deep    = vmbm_pkg::is_deep(r_req.depth) && vmbm_pkg::is_deep(rd_ent.depth);

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_req        = r_req;
        n_area       = r_area;
        n_ent        = r_ent;
        n_ea         = r_ea;
        n_elig       = r_elig;
        n_half       = r_half;
        n_diff       = r_diff;
        n_best_score = r_best_score;
        n_best_idx   = r_best_idx;
        n_best       = r_best;
        n_found      = r_found;
        n_done       = 1'b0;
        n_status     = r_status;
        n_oidx       = r_oidx;
        n_out        = r_out;
        unique case (r_state)
            vmbm_pkg::ST_IDLE: begin
                if (accept) begin
                    n_req  = in_ent;
                    n_area = AW'(i_req_width) * AW'(i_req_height);
                    case (i_req_type)
                        vmbm_pkg::REQ_WRITE: begin
                            n_done   = 1'b1;
                            n_status = !wr_ok;
                            n_oidx   = wr_ok ? i_entry_index : 6'd0;
                            n_out    = wr_ok ? in_ent : '0;
                        end
                        vmbm_pkg::REQ_READ: begin
                            if (rd_ok) begin
                                // zero area sends the fetch straight to read-out
                                n_area  = '0;
                                n_idx   = idx_ext[IW-1:0];
                                n_state = vmbm_pkg::ST_FETCH;
                            end else begin
                                n_done   = 1'b1;
                                n_status = 1'b1;
                                n_oidx   = '0;
                                n_out    = '0;
                            end
                        end
                        vmbm_pkg::REQ_FIND: begin
                            if (i_req_width == 16'd0 || i_req_height == 16'd0
                                || eff_cnt == '0) begin
                                n_done   = 1'b1;
                                n_status = 1'b1;
                                n_oidx   = '0;
                                n_out    = '0;
                            end else begin
                                n_idx        = '0;
                                n_best_score = vmbm_pkg::SCORE_LIMIT;
                                n_best_idx   = '0;
                                n_found      = 1'b0;
                                n_state      = vmbm_pkg::ST_FETCH;
                            end
                        end
                        default: begin
                            n_done   = 1'b1;
                            n_status = 1'b1;
                            n_oidx   = '0;
                            n_out    = '0;
                        end
                    endcase
                end
            end
            vmbm_pkg::ST_FETCH: begin
                n_state = (r_area == '0) ? vmbm_pkg::ST_RDOUT : vmbm_pkg::ST_EVAL;
            end
            vmbm_pkg::ST_RDOUT: begin
                n_done   = 1'b1;
                n_status = 1'b0;
                n_oidx   = idx_wide[5:0];
                n_out    = rd_ent;
                n_state  = vmbm_pkg::ST_IDLE;
            end
            vmbm_pkg::ST_EVAL: begin
                if (rd_ent == r_req) begin
                    // exact hit ends the scan
                    n_done   = 1'b1;
                    n_status = 1'b0;
                    n_oidx   = idx_wide[5:0];
                    n_out    = rd_ent;
                    n_state  = vmbm_pkg::ST_IDLE;
                end else begin
                    n_ent   = rd_ent;
                    n_ea    = AW'(rd_ent.width) * AW'(rd_ent.height);
                    n_elig  = !(d_narrow && rd_ent.depth != r_req.depth)
                              && (d_deep || rd_ent.depth == r_req.depth);
                    n_half  = d_deep && rd_ent.depth == r_req.depth;
                    n_state = vmbm_pkg::ST_DIFF;
                end
            end
            vmbm_pkg::ST_DIFF: begin
                n_diff = (r_ea >= r_area) ? (r_ea - r_area) : (r_area - r_ea);
                // skip entries whose score cannot fall below the limit
                if (r_elig && ({1'b0, n_diff} < (r_half ? {r_area, 1'b0}
                                                        : {1'b0, r_area}))) begin
                    n_state = vmbm_pkg::ST_MUL;
                end else if (last) begin
                    n_done   = 1'b1;
                    n_status = !r_found;
                    n_oidx   = r_found ? best_wide[5:0] : 6'd0;
                    n_out    = r_found ? r_best : '0;
                    n_state  = vmbm_pkg::ST_IDLE;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = vmbm_pkg::ST_FETCH;
                end
            end
            vmbm_pkg::ST_MUL: begin
                n_state = vmbm_pkg::ST_DIV;
            end
            vmbm_pkg::ST_DIV: begin
                if (div_done) begin
                    // keep the earlier entry on a tie
                    if (score < r_best_score) begin
                        n_best_score = score;
                        n_best_idx   = r_idx;
                        n_best       = r_ent;
                        n_found      = 1'b1;
                    end
                    if (last) begin
                        n_done   = 1'b1;
                        n_status = !n_found;
                        n_oidx   = n_found ? ((score < r_best_score) ? idx_wide[5:0]
                                                                      : best_wide[5:0])
                                           : 6'd0;
                        n_out    = n_found ? n_best : '0;
                        n_state  = vmbm_pkg::ST_IDLE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = vmbm_pkg::ST_FETCH;
                    end
                end
            end
            default: begin
                n_state = vmbm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= vmbm_pkg::ST_IDLE;
            r_done       <= 1'b0;
            r_found      <= 1'b0;
            r_best_score <= vmbm_pkg::SCORE_LIMIT;
        end else begin
            r_state      <= n_state;
            r_done       <= n_done;
            r_found      <= n_found;
            r_best_score <= n_best_score;
        end
        r_idx      <= n_idx;
        r_req      <= n_req;
        r_area     <= n_area;
        r_ent      <= n_ent;
        r_ea       <= n_ea;
        r_elig     <= n_elig;
        r_half     <= n_half;
        r_diff     <= n_diff;
        r_best_idx <= n_best_idx;
        r_best     <= n_best;
        r_status   <= n_status;
        r_oidx     <= n_oidx;
        r_out      <= n_out;
    end

    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_mode_index  = r_oidx;
    assign o_mode_width  = r_out.width;
    assign o_mode_height = r_out.height;
    assign o_mode_depth  = r_out.depth;

    // a result word leaves only once the sequencer is back at rest
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy) else $error("result word while busy");

    // the best score never rises above the acceptance limit
    a_score_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_best_score <= vmbm_pkg::SCORE_LIMIT) else $error("best score over limit");

    // an error word carries zero fields
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status) |-> (o_mode_index == 6'd0 && o_mode_width == 16'd0
                                  && o_mode_height == 16'd0 && o_mode_depth == 8'd0))
        else $error("error word with nonzero fields");

    // the divider finishes only while the sequencer waits for it
    a_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == vmbm_pkg::ST_DIV)) else $error("stray divider result");

endmodule

// ----- hw/rtl/vmbm_ram.sv -----
// ----------------------------------------------------------------------------
// vmbm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module vmbm_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/vmbm_div.sv -----
// ----------------------------------------------------------------------------
// vmbm_div
// Restoring divider for the match score: ten quotient bits, one per cycle.
// The caller guarantees the quotient stays below 1024.
// ----------------------------------------------------------------------------
module vmbm_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [vmbm_pkg::NUM_W-1:0]        i_num,
    input  logic [vmbm_pkg::AREA_W-1:0]       i_den,
    output logic                              o_done,
    output logic [vmbm_pkg::SCORE_W-1:0]      o_quo
);

    localparam int AW = vmbm_pkg::AREA_W;
    localparam int QW = vmbm_pkg::SCORE_W;
    localparam int CNTW = $clog2(QW);

    logic            r_busy, n_busy;
    logic            r_done, n_done;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic [AW-1:0]   r_rem, n_rem;
    logic [AW-1:0]   r_den, n_den;
    logic [QW-1:0]   r_low, n_low;
    logic [QW-1:0]   r_q, n_q;
    logic [AW:0]     rem2;
    logic [AW:0]     rem_sub;
    logic            ge;

    // one trial subtraction per cycle
    always_comb begin
        rem2    = {r_rem, r_low[QW-1]};
        rem_sub = rem2 - {1'b0, r_den};
        ge      = rem2 >= {1'b0, r_den};
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_den   = r_den;
        n_low   = r_low;
        n_q     = r_q;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = i_num[vmbm_pkg::NUM_W-1:QW];
            n_low  = i_num[QW-1:0];
            n_den  = i_den;
            n_q    = '0;
        end else if (r_busy) begin
            n_rem = ge ? rem_sub[AW-1:0] : rem2[AW-1:0];
            n_low = {r_low[QW-2:0], 1'b0};
            n_q   = {r_q[QW-2:0], ge};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNTW'(QW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_den <= n_den;
        r_low <= n_low;
        r_q   <= n_q;
    end

    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule
